FILE: hw/rtl/odf_pkg.sv
package odf_pkg;

  localparam int MAX_DIRS = 64;
  localparam int IDX_W    = $clog2(MAX_DIRS);
  localparam int CNT_W    = $clog2(MAX_DIRS + 1);
  localparam int DOT_W    = 34;
  localparam int ONE_FRAC = 28;

  // Exactly 1.0 in Q6.28, the starting best value of every search.
  localparam logic signed [DOT_W-1:0] ONE_DOT =
    {{(DOT_W-ONE_FRAC-1){1'b0}}, 1'b1, {ONE_FRAC{1'b0}}};

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic               final_dir;
  } dir_in_t;

  typedef struct packed {
    logic signed [15:0] opp_x;
    logic signed [15:0] opp_y;
    logic signed [15:0] opp_z;
    logic               end_of_run;
    logic               overflowed;
  } dir_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDJ,
    S_CAPJ,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_j;
    logic cap_j;
    logic scan_rd;
    logic next_j;
    logic clear_set;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic j_last;
    logic pipe_idle;
  } status_t;

endpackage

FILE: hw/rtl/odf_datapath.sv
module odf_datapath (
  input  logic              clk,
  input  logic              rst,
  input  odf_pkg::cmd_t     cmd,
  input  odf_pkg::dir_in_t  dir_in,
  output odf_pkg::status_t  status,
  output odf_pkg::dir_out_t result
);

  odf_pkg::vec_t mem [odf_pkg::MAX_DIRS];

  logic [odf_pkg::CNT_W-1:0] count;
  logic                      ovf;
  logic [odf_pkg::IDX_W-1:0] i_idx;
  logic [odf_pkg::IDX_W-1:0] j_idx;
  logic [odf_pkg::IDX_W-1:0] rd_addr;
  logic [odf_pkg::CNT_W-1:0] last_idx;

  odf_pkg::vec_t e0_vec;
  odf_pkg::vec_t jvec;
  odf_pkg::vec_t rd_data;
  odf_pkg::vec_t s2_vec;
  odf_pkg::vec_t s3_vec;
  odf_pkg::vec_t best_vec;

  logic s1_v, s2_v, s3_v;
  logic s1_self, s1_self_d, s2_self, s3_self;

  logic signed [31:0]               px, py, pz;
  logic signed [odf_pkg::DOT_W-1:0] dot;
  logic signed [odf_pkg::DOT_W-1:0] best_dot;

  logic store_ok;

  assign store_ok = count < odf_pkg::CNT_W'(odf_pkg::MAX_DIRS);
  assign last_idx = count - odf_pkg::CNT_W'(1);
  assign rd_addr  = cmd.rd_j ? j_idx : i_idx;

  // Direction store: one write port for loading, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      mem[count[odf_pkg::IDX_W-1:0]] <= '{x: dir_in.dir_x, y: dir_in.dir_y, z: dir_in.dir_z};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      j_idx <= '0;
      i_idx <= '0;
    end else begin
      if (cmd.load) begin
        if (store_ok) begin
          count <= count + odf_pkg::CNT_W'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.cap_j) begin
        i_idx <= '0;
      end else if (cmd.scan_rd) begin
        i_idx <= i_idx + odf_pkg::IDX_W'(1);
      end
      if (cmd.next_j) begin
        j_idx <= j_idx + odf_pkg::IDX_W'(1);
      end
      if (cmd.clear_set) begin
        count <= '0;
        ovf   <= 1'b0;
        j_idx <= '0;
      end
    end
  end

  // Entry 0 is the fallback answer when no candidate beats 1.0.
  always_ff @(posedge clk) begin
    if (cmd.load && count == '0) begin
      e0_vec <= '{x: dir_in.dir_x, y: dir_in.dir_y, z: dir_in.dir_z};
    end
    if (cmd.cap_j) begin
      jvec <= rd_data;
    end
  end

  // Scan pipeline: read, multiply, sum, compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= cmd.scan_rd;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  assign s1_self = (i_idx == j_idx);

  always_ff @(posedge clk) begin
    s1_self_d <= s1_self;
    px        <= rd_data.x * jvec.x;
    py        <= rd_data.y * jvec.y;
    pz        <= rd_data.z * jvec.z;
    s2_vec    <= rd_data;
    s2_self   <= s1_self_d;
    dot       <= odf_pkg::DOT_W'(px) + odf_pkg::DOT_W'(py) + odf_pkg::DOT_W'(pz);
    s3_vec    <= s2_vec;
    s3_self   <= s2_self;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_j) begin
      best_dot <= odf_pkg::ONE_DOT;
      best_vec <= e0_vec;
    end else if (s3_v && !s3_self && dot < best_dot) begin
      best_dot <= dot;
      best_vec <= s3_vec;
    end
  end

  assign status.scan_last = ({1'b0, i_idx} == last_idx);
  assign status.j_last    = ({1'b0, j_idx} == last_idx);
  assign status.pipe_idle = !s1_v && !s2_v && !s3_v;

  assign result.opp_x      = best_vec.x;
  assign result.opp_y      = best_vec.y;
  assign result.opp_z      = best_vec.z;
  assign result.end_of_run = status.j_last;
  assign result.overflowed = ovf;

endmodule

FILE: hw/rtl/odf_ctrl.sv
module odf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             final_dir,
  input  odf_pkg::status_t status,
  output odf_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             strobe
);

  odf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= odf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    strobe     = 1'b0;
    case (state)
      odf_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (final_dir) begin
            state_next = odf_pkg::S_RDJ;
          end
        end
      end
      odf_pkg::S_RDJ: begin
        cmd.rd_j   = 1'b1;
        state_next = odf_pkg::S_CAPJ;
      end
      odf_pkg::S_CAPJ: begin
        cmd.cap_j  = 1'b1;
        state_next = odf_pkg::S_SCAN;
      end
      odf_pkg::S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_next = odf_pkg::S_DRAIN;
        end
      end
      odf_pkg::S_DRAIN: begin
        if (status.pipe_idle) begin
          state_next = odf_pkg::S_EMIT;
        end
      end
      odf_pkg::S_EMIT: begin
        strobe = 1'b1;
        if (status.j_last) begin
          cmd.clear_set = 1'b1;
          state_next    = odf_pkg::S_IDLE;
        end else begin
          cmd.next_j = 1'b1;
          state_next = odf_pkg::S_RDJ;
        end
      end
      default: begin
        state_next = odf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/opposite_direction_finder_unit.sv
// Loading: one word per cycle while busy is low.
// Search: each result comes from a one-entry-per-cycle scan of the direction store
// read port over all n stored directions.
// Results appear one per strobe cycle and cannot be stalled by the receiver.
// Synchronous reset empties the set and returns to idle; store contents are not cleared.
module opposite_direction_finder_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  odf_pkg::dir_in_t  dir_in,
  output logic              strobe,
  output odf_pkg::dir_out_t result
);

  odf_pkg::cmd_t    cmd;
  odf_pkg::status_t status;

  odf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .final_dir (dir_in.final_dir),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .strobe    (strobe)
  );

  odf_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .dir_in (dir_in),
    .status (status),
    .result (result)
  );

endmodule

FILE: hw/rtl/odf_checker.sv
module odf_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input odf_pkg::dir_in_t  dir_in,
  input logic              strobe,
  input odf_pkg::dir_out_t result
);

  // A result word only comes out during a search.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("result strobe while not busy");

  a_final_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && dir_in.final_dir) |=> busy)
    else $error("final word did not start the search");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !dir_in.final_dir) |=> !busy)
    else $error("non-final word made the unit busy");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.end_of_run) |=> !busy)
    else $error("unit still busy after the last result");

  a_strobe_gap: assert property (@(posedge clk) disable iff (rst) strobe |=> !strobe)
    else $error("two result strobes in a row");

endmodule

bind opposite_direction_finder_unit odf_checker u_odf_checker (.*);
